/* design/trd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and codes for the triangle rasterizer with depth test.
// No dependencies.
package trd_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;
  localparam int COL_BITS      = $clog2(SCREEN_WIDTH);
  localparam int ROW_BITS      = $clog2(SCREEN_HEIGHT);
  localparam int ADDR_BITS     = COL_BITS + ROW_BITS;
  localparam int STORE_WORDS   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int DEPTH_BITS    = 16;
  localparam int FRAC          = 4;
  localparam int DIFF_BITS     = 18;
  localparam int W_BITS        = 36;
  localparam int NUM_BITS      = 54;

  localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = '1;
  localparam logic signed [12:0] MAX_COL = 13'(SCREEN_WIDTH - 1);
  localparam logic signed [12:0] MAX_ROW = 13'(SCREEN_HEIGHT - 1);

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AREA, S_AREA_FIN, S_EDGE, S_NORM, S_CHECK,
    S_MAC, S_DIV_PREP, S_DIV, S_EMIT_PIX, S_EMIT_CLR
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_AREA_MUL, OP_AREA_FIN, OP_EDGE_MUL,
    OP_NORM, OP_MAC, OP_DIV_PREP, OP_DIV, OP_EMIT_PIX, OP_EMIT_CLR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic active;
    logic covered;
    logic out_free;
  } stat_t;

endpackage

/* design/triangle_raster_depth_test_top.sv */
`timescale 1ns / 1ps
// Top level of the triangle rasterizer with depth test.
// Depends on trd_pkg, trd_ctrl and trd_datapath.
//
// One item at a time. After reset the block sweeps the 16384-word depth store
// to far, one word per cycle, and takes no item until the sweep is done. A
// load runs three steps of the shared edge multiplier for the area. A pixel
// runs the shared multiplier for the edge functions; when covered it then
// runs the depth multiply-accumulate and the restoring divider. A clear goes
// straight to the output register.
// The output register holds a result until taken; a new item is accepted while
// it waits, and the next result stalls until the register is free.
module triangle_raster_depth_test_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [15:0] vert0_x,
  input  logic signed [15:0] vert0_y,
  input  logic [15:0]        vert0_depth,
  input  logic signed [15:0] vert1_x,
  input  logic signed [15:0] vert1_y,
  input  logic [15:0]        vert1_depth,
  input  logic signed [15:0] vert2_x,
  input  logic signed [15:0] vert2_y,
  input  logic [15:0]        vert2_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         pixel_x,
  output logic [7:0]         pixel_y,
  output logic [15:0]        pixel_depth,
  output logic               drawn,
  output logic               finished
);
  import trd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  trd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  trd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .vert0_x     (vert0_x),
    .vert0_y     (vert0_y),
    .vert0_depth (vert0_depth),
    .vert1_x     (vert1_x),
    .vert1_y     (vert1_y),
    .vert1_depth (vert1_depth),
    .vert2_x     (vert2_x),
    .vert2_y     (vert2_y),
    .vert2_depth (vert2_depth),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_depth (pixel_depth),
    .drawn       (drawn),
    .finished    (finished)
  );

endmodule

/* design/trd_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the rasterizer: issues datapath commands per action.
// Depends on trd_pkg.
module trd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    action,
  input  trd_pkg::stat_t stat,
  output trd_pkg::cmd_t  cmd
);
  import trd_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    case (state)
      S_INIT: if (stat.init_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_LOAD:  state_next = S_AREA;
            ACT_PIXEL: if (stat.active) state_next = S_EDGE;
            ACT_CLEAR: state_next = S_EMIT_CLR;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_AREA: begin
        if (cnt == 4'd2) state_next = S_AREA_FIN;
        else cnt_next = cnt + 4'd1;
      end
      S_AREA_FIN: state_next = S_IDLE;
      S_EDGE: begin
        if (cnt == 4'd6) state_next = S_NORM;
        else cnt_next = cnt + 4'd1;
      end
      S_NORM:  state_next = S_CHECK;
      S_CHECK: state_next = stat.covered ? S_MAC : S_EMIT_PIX;
      S_MAC: begin
        if (cnt == 4'd15) state_next = S_DIV_PREP;
        else cnt_next = cnt + 4'd1;
      end
      S_DIV_PREP: state_next = S_DIV;
      S_DIV: begin
        if (cnt == 4'd15) state_next = S_EMIT_PIX;
        else cnt_next = cnt + 4'd1;
      end
      S_EMIT_PIX: if (stat.out_free) state_next = S_IDLE;
      S_EMIT_CLR: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.step = cnt;
    cmd.op   = OP_NONE;
    case (state)
      S_INIT: cmd.op = OP_INIT;
      S_IDLE: if (accept && action_t'(action) == ACT_LOAD) cmd.op = OP_LOAD;
      S_AREA:     cmd.op = OP_AREA_MUL;
      S_AREA_FIN: cmd.op = OP_AREA_FIN;
      S_EDGE:     cmd.op = OP_EDGE_MUL;
      S_NORM:     cmd.op = OP_NORM;
      S_MAC:      cmd.op = OP_MAC;
      S_DIV_PREP: cmd.op = OP_DIV_PREP;
      S_DIV:      cmd.op = OP_DIV;
      S_EMIT_PIX: if (stat.out_free) cmd.op = OP_EMIT_PIX;
      S_EMIT_CLR: if (stat.out_free) cmd.op = OP_EMIT_CLR;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

/* design/trd_datapath.sv */
`timescale 1ns / 1ps
// Rasterizer datapath: triangle and box registers, shared edge multiplier,
// depth multiply-accumulate, restoring divider, depth store and output register.
// Depends on trd_pkg.
module trd_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  trd_pkg::cmd_t         cmd,
  output trd_pkg::stat_t        stat,
  input  logic signed [15:0]    vert0_x,
  input  logic signed [15:0]    vert0_y,
  input  logic [15:0]           vert0_depth,
  input  logic signed [15:0]    vert1_x,
  input  logic signed [15:0]    vert1_y,
  input  logic [15:0]           vert1_depth,
  input  logic signed [15:0]    vert2_x,
  input  logic signed [15:0]    vert2_y,
  input  logic [15:0]           vert2_depth,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_x,
  output logic [7:0]            pixel_y,
  output logic [15:0]           pixel_depth,
  output logic                  drawn,
  output logic                  finished
);
  import trd_pkg::*;

  function automatic logic signed [12:0] px_floor(input logic signed [15:0] v);
    return 13'(v >>> FRAC);
  endfunction

  function automatic logic signed [12:0] px_ceil(input logic signed [15:0] v);
    logic signed [16:0] t;
    t = 17'(v) + 17'sd15;
    return 13'(t >>> FRAC);
  endfunction

  function automatic logic [7:0] px_clamp(input logic signed [12:0] v,
                                          input logic signed [12:0] hi);
    if (v < 13'sd0) return 8'd0;
    else if (v > hi) return 8'(hi);
    else return 8'(v);
  endfunction

  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic [15:0]        vd [3];
  logic [7:0]         box_l, box_r, box_b, box_t;
  logic [7:0]         col, row;
  logic               active;
  logic               area_neg;
  logic [W_BITS-1:0]  abs_area;
  logic signed [W_BITS-1:0] w [3];
  logic signed [W_BITS-1:0] prod;
  logic [NUM_BITS-1:0] acc, rem, dsr;
  logic [DEPTH_BITS-1:0] quo;
  logic [ADDR_BITS-1:0] sweep, clr_ptr;
  logic [DEPTH_BITS-1:0] mem [STORE_WORDS];
  logic [DEPTH_BITS-1:0] mem_q;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_wa, rd_addr;
  logic [DEPTH_BITS-1:0] mem_wd;

  // load-time box
  logic signed [15:0] minx, maxx, miny, maxy;
  logic signed [12:0] l, r, b, t;
  logic               box_on;

  always_comb begin
    minx = vert0_x; maxx = vert0_x; miny = vert0_y; maxy = vert0_y;
    if (vert1_x < minx) minx = vert1_x;
    if (vert2_x < minx) minx = vert2_x;
    if (vert1_x > maxx) maxx = vert1_x;
    if (vert2_x > maxx) maxx = vert2_x;
    if (vert1_y < miny) miny = vert1_y;
    if (vert2_y < miny) miny = vert2_y;
    if (vert1_y > maxy) maxy = vert1_y;
    if (vert2_y > maxy) maxy = vert2_y;
    l = px_floor(minx);
    r = px_ceil(maxx);
    b = px_floor(miny);
    t = px_ceil(maxy);
    box_on = !(r < 13'sd0 || l > MAX_COL || t < 13'sd0 || b > MAX_ROW);
  end

  // shared edge multiplier
  logic               vert_mode, second;
  logic [1:0]         e;
  logic signed [DIFF_BITS-1:0] ax, ay, bx, by, px, py, opa, opb;
  logic signed [W_BITS-1:0]    prod_next;
  logic [3:0]         acc_idx;

  always_comb begin
    vert_mode = (cmd.op == OP_AREA_MUL);
    e         = cmd.step[2:1];
    second    = cmd.step[0];
    case (e)
      2'd0: begin
        ax = 18'(vx[1]); ay = 18'(vy[1]); bx = 18'(vx[2]); by = 18'(vy[2]);
      end
      2'd1: begin
        ax = 18'(vx[2]); ay = 18'(vy[2]); bx = 18'(vx[0]); by = 18'(vy[0]);
      end
      default: begin
        ax = 18'(vx[0]); ay = 18'(vy[0]); bx = 18'(vx[1]); by = 18'(vy[1]);
      end
    endcase
    if (vert_mode) begin
      px = 18'(vx[0]);
      py = 18'(vy[0]);
    end else begin
      px = $signed({{(DIFF_BITS - 8 - FRAC){1'b0}}, col, {FRAC{1'b0}}});
      py = $signed({{(DIFF_BITS - 8 - FRAC){1'b0}}, row, {FRAC{1'b0}}});
    end
    opa       = second ? (by - ay) : (bx - ax);
    opb       = second ? (px - ax) : (py - ay);
    prod_next = opa * opb;
    acc_idx   = cmd.step - 4'd1;
  end

  logic covered, last;
  assign covered = (abs_area != '0) && !w[0][W_BITS-1] && !w[1][W_BITS-1]
                   && !w[2][W_BITS-1];
  assign last    = (col == box_r) && (row == box_t);
  assign rd_addr = {row[ROW_BITS-1:0], col[COL_BITS-1:0]};

  assign stat = {(sweep == ADDR_BITS'(STORE_WORDS - 1)), active, covered,
                 (!out_valid || out_ready)};

  logic [NUM_BITS-1:0] mac_sum;
  logic [3:0]          bit_idx;
  always_comb begin
    bit_idx = ~cmd.step;
    mac_sum = (acc << 1)
            + (vd[0][bit_idx] ? NUM_BITS'($unsigned(w[0])) : '0)
            + (vd[1][bit_idx] ? NUM_BITS'($unsigned(w[1])) : '0)
            + (vd[2][bit_idx] ? NUM_BITS'($unsigned(w[2])) : '0);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep;
    mem_wd = DEPTH_FAR;
    case (cmd.op)
      OP_INIT: mem_we = 1'b1;
      OP_EMIT_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_ptr;
      end
      OP_EMIT_PIX: begin
        mem_we = covered && (quo < mem_q);
        mem_wa = rd_addr;
        mem_wd = quo;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0; vy[i] <= '0; vd[i] <= '0;
      end
      box_l <= '0; box_r <= '0; box_b <= '0; box_t <= '0;
      col <= '0; row <= '0;
      active <= 1'b0;
      area_neg <= 1'b0;
      abs_area <= '0;
      sweep <= '0;
      clr_ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op inside {OP_EMIT_PIX, OP_EMIT_CLR}) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_INIT: sweep <= sweep + 1'b1;
        OP_LOAD: begin
          vx[0] <= vert0_x; vy[0] <= vert0_y; vd[0] <= vert0_depth;
          vx[1] <= vert1_x; vy[1] <= vert1_y; vd[1] <= vert1_depth;
          vx[2] <= vert2_x; vy[2] <= vert2_y; vd[2] <= vert2_depth;
          box_l  <= px_clamp(l, MAX_COL);
          box_r  <= px_clamp(r, MAX_COL);
          box_b  <= px_clamp(b, MAX_ROW);
          box_t  <= px_clamp(t, MAX_ROW);
          col    <= px_clamp(l, MAX_COL);
          row    <= px_clamp(b, MAX_ROW);
          active <= box_on;
        end
        OP_AREA_FIN: begin
          area_neg <= w[0][W_BITS-1];
          abs_area <= w[0][W_BITS-1] ? W_BITS'(-w[0]) : W_BITS'(w[0]);
        end
        OP_EMIT_PIX: begin
          pixel_x     <= col;
          pixel_y     <= row;
          pixel_depth <= covered ? quo : '0;
          drawn       <= covered && (quo < mem_q);
          finished    <= last;
          if (last) begin
            active <= 1'b0;
          end else if (col >= box_r) begin
            col <= box_l;
            row <= row + 8'd1;
          end else begin
            col <= col + 8'd1;
          end
        end
        OP_EMIT_CLR: begin
          pixel_x     <= 8'(clr_ptr[COL_BITS-1:0]);
          pixel_y     <= 8'(clr_ptr[ADDR_BITS-1:COL_BITS]);
          pixel_depth <= '0;
          drawn       <= 1'b0;
          finished    <= (clr_ptr == ADDR_BITS'(STORE_WORDS - 1));
          clr_ptr     <= clr_ptr + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // arithmetic payload, no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_AREA_MUL, OP_EDGE_MUL: begin
        if (cmd.step < 4'd6) prod <= prod_next;
        if (cmd.step != 4'd0) begin
          if (acc_idx[0]) w[acc_idx[2:1]] <= w[acc_idx[2:1]] - prod;
          else w[acc_idx[2:1]] <= prod;
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) w[i] <= area_neg ? -w[i] : w[i];
        acc <= '0;
        quo <= '0;
      end
      OP_MAC: acc <= mac_sum;
      OP_DIV_PREP: begin
        rem <= acc;
        dsr <= NUM_BITS'({abs_area, {(DEPTH_BITS-1){1'b0}}});
        quo <= '0;
      end
      OP_DIV: begin
        if (rem >= dsr) begin
          rem <= rem - dsr;
          quo <= {quo[DEPTH_BITS-2:0], 1'b1};
        end else begin
          quo <= {quo[DEPTH_BITS-2:0], 1'b0};
        end
        dsr <= dsr >> 1;
      end
      default: ;
    endcase
  end

endmodule

/* design/trd_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the rasterizer result channel, bound to the top level.
// Depends on triangle_raster_depth_test_top.
module trd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  pixel_x,
  input logic [7:0]  pixel_y,
  input logic [15:0] pixel_depth,
  input logic        drawn,
  input logic        finished
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_depth) && $stable(drawn) && $stable(finished))
    else $error("stalled result changed");

  a_drawn_near: assert property (@(posedge clk) disable iff (rst)
    out_valid && drawn |-> pixel_depth != 16'hffff)
    else $error("far depth reported drawn");

  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_x < 8'd128 && pixel_y < 8'd128)
    else $error("pixel off screen");

endmodule

bind triangle_raster_depth_test_top trd_checker u_chk (.*);

/* tb/triangle_raster_depth_test_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for triangle_raster_depth_test_top: a queue-fed driver, a monitor,
// and an in-bench raster/depth predictor. Depends on trd_pkg and the design.
module triangle_raster_depth_test_top_test;
  import trd_pkg::*;

  typedef struct packed {
    logic [1:0] act;
    logic signed [15:0] x0, y0;
    logic [15:0] d0;
    logic signed [15:0] x1, y1;
    logic [15:0] d1;
    logic signed [15:0] x2, y2;
    logic [15:0] d2;
  } tri_item_t;

  typedef struct packed {
    logic [7:0] px, py;
    logic [15:0] pd;
    logic dr, fin;
  } pix_res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic [1:0] action = '0;
  logic signed [15:0] vert0_x = '0, vert0_y = '0, vert1_x = '0, vert1_y = '0;
  logic signed [15:0] vert2_x = '0, vert2_y = '0;
  logic [15:0] vert0_depth = '0, vert1_depth = '0, vert2_depth = '0;
  logic [7:0] pixel_x, pixel_y;
  logic [15:0] pixel_depth;
  logic drawn, finished;

  triangle_raster_depth_test_top u_dut (.*);

  initial forever #10 clk = ~clk;

  // predictor state
  longint tx[3], ty[3], td[3];
  longint area2;
  int box_l, box_r, box_b, box_t, col, row;
  bit box_on;
  logic [15:0] zbuf[STORE_WORDS];
  int clr_ptr;

  tri_item_t pending_q[$];
  pix_res_t expected_q[$];
  int errors = 0, shown = 0, idle_cycles = 0;
  bit stim_done = 0, hold_off = 0;

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                     longint px, longint py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
  endfunction

  function automatic longint floor16(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint ceil16(longint v);
    return -((-v) >>> FRAC);
  endfunction

  function automatic int clampi(longint v, int hi);
    return v < 0 ? 0 : (v > hi ? hi : int'(v));
  endfunction

  task automatic predict_transfer(tri_item_t it);
    pix_res_t r;
    longint w0, w1, w2, a, q, px, py, mnx, mxx, mny, mxy;
    int addr;
    bit last;
    case (it.act)
      ACT_LOAD: begin
        tx[0] = it.x0; ty[0] = it.y0; td[0] = it.d0;
        tx[1] = it.x1; ty[1] = it.y1; td[1] = it.d1;
        tx[2] = it.x2; ty[2] = it.y2; td[2] = it.d2;
        area2 = edge_fn(tx[1], ty[1], tx[2], ty[2], tx[0], ty[0]);
        mnx = tx[0]; mxx = tx[0]; mny = ty[0]; mxy = ty[0];
        for (int i = 1; i < 3; i++) begin
          if (tx[i] < mnx) mnx = tx[i];
          if (tx[i] > mxx) mxx = tx[i];
          if (ty[i] < mny) mny = ty[i];
          if (ty[i] > mxy) mxy = ty[i];
        end
        mnx = floor16(mnx); mxx = ceil16(mxx); mny = floor16(mny); mxy = ceil16(mxy);
        box_on = !(mxx < 0 || mnx > SCREEN_WIDTH - 1 || mxy < 0 || mny > SCREEN_HEIGHT - 1);
        box_l = clampi(mnx, SCREEN_WIDTH - 1); box_r = clampi(mxx, SCREEN_WIDTH - 1);
        box_b = clampi(mny, SCREEN_HEIGHT - 1); box_t = clampi(mxy, SCREEN_HEIGHT - 1);
        col = box_l; row = box_b;
      end
      ACT_PIXEL: if (box_on) begin
        px = longint'(col) << FRAC; py = longint'(row) << FRAC;
        w0 = edge_fn(tx[1], ty[1], tx[2], ty[2], px, py);
        w1 = edge_fn(tx[2], ty[2], tx[0], ty[0], px, py);
        w2 = edge_fn(tx[0], ty[0], tx[1], ty[1], px, py);
        a = area2;
        last = (col == box_r && row == box_t);
        addr = row * SCREEN_WIDTH + col;
        r = '0;
        if (a < 0) begin
          a = -a; w0 = -w0; w1 = -w1; w2 = -w2;
        end
        if (a != 0 && w0 >= 0 && w1 >= 0 && w2 >= 0) begin
          q = (w0 * td[0] + w1 * td[1] + w2 * td[2]) / a;
          r.pd = q > 65535 ? 16'hFFFF : q[15:0];
          if (r.pd < zbuf[addr]) begin
            zbuf[addr] = r.pd;
            r.dr = 1;
          end
        end
        r.px = col; r.py = row; r.fin = last;
        expected_q.insert(expected_q.size(), r);
        if (last) box_on = 0;
        else if (col >= box_r) begin
          col = box_l; row = row + 1;
        end else col = col + 1;
      end
      ACT_CLEAR: begin
        r = '0;
        zbuf[clr_ptr] = DEPTH_FAR;
        r.px = clr_ptr % SCREEN_WIDTH; r.py = clr_ptr / SCREEN_WIDTH;
        r.fin = (clr_ptr == STORE_WORDS - 1);
        clr_ptr = r.fin ? 0 : clr_ptr + 1;
        expected_q.insert(expected_q.size(), r);
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return -($urandom_range(0, 400));
      2: return $urandom_range(1900, 2200);
      default: return $urandom_range(0, 16 * 40);
    endcase
  endfunction

  function automatic tri_item_t rand_tri();
    tri_item_t t;
    t.act = ACT_LOAD;
    t.x0 = rand_coord(); t.y0 = rand_coord();
    t.x1 = t.x0 + $signed(16'($urandom_range(0, 160)) - 16'sd80);
    t.y1 = t.y0 + $signed(16'($urandom_range(0, 160)) - 16'sd80);
    t.x2 = t.x0 + $signed(16'($urandom_range(0, 160)) - 16'sd80);
    t.y2 = t.y0 + $signed(16'($urandom_range(0, 160)) - 16'sd80);
    t.d0 = $urandom; t.d1 = $urandom; t.d2 = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      t.x1 = $urandom; t.y2 = $urandom;
    end
    return t;
  endfunction

  function automatic tri_item_t op_item(logic [1:0] a);
    tri_item_t t;
    t = '0;
    t.act = a;
    t.x0 = $urandom; t.d2 = $urandom;
    return t;
  endfunction

  task automatic push_tri(tri_item_t t, int steps);
    pending_q.insert(pending_q.size(), t);
    for (int i = 0; i < steps; i++) pending_q.insert(pending_q.size(), op_item(ACT_PIXEL));
  endtask

  initial begin
    tri_item_t t;
    int n;
    for (int i = 0; i < STORE_WORDS; i++) zbuf[i] = DEPTH_FAR;
    area2 = 0; box_on = 0; clr_ptr = 0; col = 0; row = 0;
    box_l = 0; box_r = 0; box_b = 0; box_t = 0;
    for (int i = 0; i < 3; i++) begin
      tx[i] = 0; ty[i] = 0; td[i] = 0;
    end
    // directed: step before load, unused code, clear, small tri, degenerate,
    // offscreen, extreme coords, saturating depth, both windings
    pending_q.insert(pending_q.size(), op_item(ACT_PIXEL));
    pending_q.insert(pending_q.size(), op_item(2'd3));
    pending_q.insert(pending_q.size(), op_item(ACT_CLEAR));
    t = '{ACT_LOAD, 16'sd0, 16'sd0, 16'd0, 16'sd64, 16'sd0, 16'd65535,
          16'sd0, 16'sd64, 16'd1000};
    push_tri(t, 26);
    t = '{ACT_LOAD, 16'sd0, 16'sd64, 16'd5, 16'sd64, 16'sd0, 16'd7,
          16'sd0, 16'sd0, 16'd9};
    push_tri(t, 4);
    t = '{ACT_LOAD, 16'sd16, 16'sd16, 16'd0, 16'sd32, 16'sd32, 16'd0,
          16'sd48, 16'sd48, 16'd0};
    push_tri(t, 3);
    t = '{ACT_LOAD, 16'sh8000, 16'sh8000, 16'hFFFF, -16'sd32000, 16'sh8000,
          16'h0, 16'sh8000, -16'sd32000, 16'h8000};
    push_tri(t, 2);
    t = '{ACT_LOAD, 16'sd32767, 16'sd32767, 16'hFFFF, 16'sh8000, 16'sd2000,
          16'hFFFF, 16'sd2040, 16'sh8000, 16'hFFFF};
    push_tri(t, 6);
    pending_q.insert(pending_q.size(), op_item(ACT_CLEAR));
    n = pending_q.size();
    while (n < 1700) begin
      case ($urandom_range(0, 9))
        0: pending_q.insert(pending_q.size(), op_item(ACT_CLEAR));
        1: pending_q.insert(pending_q.size(), op_item(2'($urandom_range(1, 3))));
        default: push_tri(rand_tri(), $urandom_range(1, 40));
      endcase
      n = pending_q.size();
    end
    // occasional full clear sweep is too long; do a partial one
    for (int i = 0; i < 300; i++) pending_q.insert(pending_q.size(), op_item(ACT_CLEAR));
    repeat (5) @(posedge clk);
    rst <= 0;
  end

  // driver
  int gap = 0, burst = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_transfer(pending_q.pop_front());
      end
      if (pending_q.size() == 0) begin
        in_valid <= 0;
        stim_done <= 1;
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 0;
      end else begin
        if (burst == 0) begin
          burst <= $urandom_range(1, 30);
          gap <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end else burst <= burst - 1;
        in_valid <= 1;
        {action, vert0_x, vert0_y, vert0_depth, vert1_x, vert1_y, vert1_depth,
         vert2_x, vert2_y, vert2_depth} <= pending_q[0];
      end
    end
  end

  // receiver stall pattern with one long hold-off
  int rx_cnt = 0;
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 1;
    hold_off <= (rx_cnt >= 20000 && rx_cnt < 22000);
    if (rst) out_ready <= 0;
    else if (hold_off) out_ready <= 0;
    else if ((rx_cnt / 500) % 3 == 0) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk) begin
    pix_res_t e, a;
    a = {pixel_x, pixel_y, pixel_depth, drawn, finished};
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          $display("unexpected transfer: %p", a);
          shown++;
        end
      end else begin
        e = expected_q.pop_front();
        if (e !== a) begin
          errors++;
          if (shown < 10) begin
            $display("mismatch: expected %p actual %p", e, a);
            shown++;
          end
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    int tail;
    tail = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && expected_q.size() == 0) tail++;
      if (idle_cycles > 100000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (tail > 200) begin
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
      end
    end
  end
endmodule
